// ===== hw/rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants for the ring buffer deque.
// ----------------------------------------------------------------------------
package rbd_pkg;

   // Capacity must stay a power of two: slot arithmetic wraps by truncation.
   localparam int DEPTH        = 16;
   localparam int ELEMENT_BITS = 32;
   localparam int SLOT_BITS    = $clog2(DEPTH);
   localparam int COUNT_BITS   = SLOT_BITS + 1;
   localparam int MODE_BITS    = 3;
   localparam int POS_BITS     = 4;
   localparam int STATUS_BITS  = 2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_READ       = 3'd4,
      MODE_OVERWRITE  = 3'd5
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   // Where the result element comes from.
   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_VALUE = 2'd1,
      SRC_RAM   = 2'd2
   } elem_src_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_RESP = 2'd2
   } fsm_state_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic capture;   // latch the request beat
      logic exec;      // perform the operation
   } dp_cmd_type;

endpackage

// ===== hw/rtl/ring_buffer_deque.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue in a circular 16-entry store.
// ----------------------------------------------------------------------------
// Sequence: a request beat is captured, then executed; the registered RAM
//   read lands as the response is shown.
// One operation is in flight at a time: no new request beat is taken until
//   the response has been taken, set by the single RAM read port and the
//   head/count update of each operation.
// Reset: synchronous, active high; clears head, count and sequencer state.
//   Storage is not cleared; only entries inside the held range are read.
// ----------------------------------------------------------------------------
module ring_buffer_deque (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rbd_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [rbd_pkg::POS_BITS-1:0]        req_position,
   input  logic [rbd_pkg::ELEMENT_BITS-1:0]    req_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rbd_pkg::ELEMENT_BITS-1:0]    rsp_element,
   output logic [rbd_pkg::COUNT_BITS-1:0]      rsp_count,
   output logic [rbd_pkg::STATUS_BITS-1:0]     rsp_status
);

   // Commands from the sequencer: capture latches the request beat,
   // exec applies it to head, count and storage.
   rbd_pkg::dp_cmd_type cmd;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath keeps the head slot and fill count; the response fields are
   // all driven from registers, so they hold steady while stalled.
   rbd_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

   // Any error status carries a zero element.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != rbd_pkg::ST_OK) |-> rsp_element == '0)
      else $error("error response with nonzero element");

   // Count never exceeds capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= rbd_pkg::COUNT_BITS'(rbd_pkg::DEPTH))
      else $error("fill count above capacity");

   // One operation in flight: no request taken while a response is pending.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while response pending");

   // An accepted request is executed, then shows its response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> ##1 rsp_valid)
      else $error("response not presented on time");

endmodule

// ===== hw/rtl/rbd_ram.sv =====
// ----------------------------------------------------------------------------
// rbd_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];   // old data on same-address write
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbd_ctrl
// Sequencer: accept a beat, execute it, hold the response until taken.
// ----------------------------------------------------------------------------
module rbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rbd_pkg::dp_cmd_type cmd
);

   rbd_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbd_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rbd_pkg::FSM_IDLE: begin
            if (req_valid) state_in = rbd_pkg::FSM_EXEC;
         end
         rbd_pkg::FSM_EXEC: begin
            state_in = rbd_pkg::FSM_RESP;
         end
         rbd_pkg::FSM_RESP: begin
            if (!rsp_stall) state_in = rbd_pkg::FSM_IDLE;
         end
         default: begin
            state_in = rbd_pkg::FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      case (state_ff)
         rbd_pkg::FSM_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         rbd_pkg::FSM_EXEC: begin
            cmd.exec = 1'b1;
         end
         rbd_pkg::FSM_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      // no request is taken while in reset
      if (reset) begin
         req_stall   = 1'b1;
         cmd.capture = 1'b0;
      end
   end

endmodule

// ===== hw/rtl/rbd_datapath.sv =====
// ----------------------------------------------------------------------------
// rbd_datapath
// Head pointer, fill count, request latch and storage access.
// ----------------------------------------------------------------------------
module rbd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rbd_pkg::dp_cmd_type                 cmd,
   input  logic [rbd_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [rbd_pkg::POS_BITS-1:0]        req_position,
   input  logic [rbd_pkg::ELEMENT_BITS-1:0]    req_value,
   output logic [rbd_pkg::ELEMENT_BITS-1:0]    rsp_element,
   output logic [rbd_pkg::COUNT_BITS-1:0]      rsp_count,
   output logic [rbd_pkg::STATUS_BITS-1:0]     rsp_status
);

   logic [rbd_pkg::MODE_BITS-1:0]    mode_ff;
   logic [rbd_pkg::POS_BITS-1:0]     position_ff;
   logic [rbd_pkg::ELEMENT_BITS-1:0] value_ff;

   logic [rbd_pkg::SLOT_BITS-1:0]  head_ff, head_in;
   logic [rbd_pkg::COUNT_BITS-1:0] count_ff, count_in;
   rbd_pkg::status_type            status_ff, status_in;
   rbd_pkg::elem_src_type          src_ff, src_in;

   logic                             ram_wr, ram_rd;
   logic [rbd_pkg::SLOT_BITS-1:0]    ram_addr;
   logic [rbd_pkg::ELEMENT_BITS-1:0] ram_q;

   logic                           is_full, is_empty, in_range;
   logic [rbd_pkg::SLOT_BITS-1:0]  slot_back, slot_last, slot_pos, head_dec, head_inc;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         position_ff <= req_position;
         value_ff    <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         count_ff  <= '0;
         status_ff <= rbd_pkg::ST_OK;
         src_ff    <= rbd_pkg::SRC_ZERO;
      end else if (cmd.exec) begin
         head_ff   <= head_in;
         count_ff  <= count_in;
         status_ff <= status_in;
         src_ff    <= src_in;
      end
   end

   // Slot math wraps modulo DEPTH by truncation.
   assign is_full   = (count_ff == rbd_pkg::COUNT_BITS'(rbd_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);
   assign in_range  = ({1'b0, position_ff} < count_ff);
   assign slot_back = head_ff + count_ff[rbd_pkg::SLOT_BITS-1:0];
   assign slot_last = slot_back - 1'b1;
   assign slot_pos  = head_ff + position_ff;
   assign head_dec  = head_ff - 1'b1;
   assign head_inc  = head_ff + 1'b1;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = rbd_pkg::ST_OK;
      src_in    = rbd_pkg::SRC_ZERO;
      ram_wr    = 1'b0;
      ram_rd    = 1'b0;
      ram_addr  = head_ff;
      case (rbd_pkg::mode_type'(mode_ff))
         rbd_pkg::MODE_PUSH_FRONT: begin
            if (is_full) begin
               status_in = rbd_pkg::ST_FULL;
            end else begin
               head_in  = head_dec;
               count_in = count_ff + 1'b1;
               ram_wr   = cmd.exec;
               ram_addr = head_dec;
               src_in   = rbd_pkg::SRC_VALUE;
            end
         end
         rbd_pkg::MODE_PUSH_BACK: begin
            if (is_full) begin
               status_in = rbd_pkg::ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               ram_wr   = cmd.exec;
               ram_addr = slot_back;
               src_in   = rbd_pkg::SRC_VALUE;
            end
         end
         rbd_pkg::MODE_POP_FRONT: begin
            if (is_empty) begin
               status_in = rbd_pkg::ST_EMPTY;
            end else begin
               head_in  = head_inc;
               count_in = count_ff - 1'b1;
               ram_rd   = cmd.exec;
               ram_addr = head_ff;
               src_in   = rbd_pkg::SRC_RAM;
            end
         end
         rbd_pkg::MODE_POP_BACK: begin
            if (is_empty) begin
               status_in = rbd_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
               ram_rd   = cmd.exec;
               ram_addr = slot_last;
               src_in   = rbd_pkg::SRC_RAM;
            end
         end
         rbd_pkg::MODE_READ: begin
            if (!in_range) begin
               status_in = rbd_pkg::ST_RANGE;
            end else begin
               ram_rd   = cmd.exec;
               ram_addr = slot_pos;
               src_in   = rbd_pkg::SRC_RAM;
            end
         end
         rbd_pkg::MODE_OVERWRITE: begin
            if (!in_range) begin
               status_in = rbd_pkg::ST_RANGE;
            end else begin
               ram_rd   = cmd.exec;
               ram_wr   = cmd.exec;
               ram_addr = slot_pos;
               src_in   = rbd_pkg::SRC_RAM;
            end
         end
         default: begin
            status_in = rbd_pkg::ST_OK;   // unused codes: no effect
         end
      endcase
   end

   rbd_ram #(
      .WIDTH (rbd_pkg::ELEMENT_BITS),
      .DEPTH (rbd_pkg::DEPTH)
   ) u_storage (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_addr),
      .wr_data (value_ff),
      .rd_en   (ram_rd),
      .rd_addr (ram_addr),
      .rd_data (ram_q)
   );

   always_comb begin
      case (src_ff)
         rbd_pkg::SRC_VALUE: rsp_element = value_ff;
         rbd_pkg::SRC_RAM:   rsp_element = ram_q;
         default:            rsp_element = '0;
      endcase
   end

   assign rsp_count  = count_ff;
   assign rsp_status = status_ff;

endmodule

// ===== tb/sv/ring_buffer_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque_tb
// Self-checking bench for the ring buffer deque: a directed table of
// corner cases (empty, full, range errors, unused codes, head wrap) and a
// long random run that swings the fill level between empty and full. Every
// response beat is checked against an in-bench deque model or a typed result.
// ----------------------------------------------------------------------------
module ring_buffer_deque_tb;

   // Mode codes the block ignores (outside the package enum).
   localparam logic [rbd_pkg::MODE_BITS-1:0] MODE_UNUSED_A = 3'd6;
   localparam logic [rbd_pkg::MODE_BITS-1:0] MODE_UNUSED_B = 3'd7;

   localparam int RANDOM_OPS     = 1000;
   localparam int QUIET_TAIL     = 120;   // last random beats run with no idling
   localparam int DRAIN_CYCLES   = 8;     // cycles waited after the last response
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

   typedef struct packed {
      logic [rbd_pkg::ELEMENT_BITS-1:0] element;
      logic [rbd_pkg::COUNT_BITS-1:0]   count;
      rbd_pkg::status_type              status;
   } deque_result_type;

   // One directed row; reps > 1 repeats the op with value + i.
   typedef struct packed {
      logic [rbd_pkg::MODE_BITS-1:0]    mode;
      logic [rbd_pkg::POS_BITS-1:0]     position;
      logic [rbd_pkg::ELEMENT_BITS-1:0] value;
      logic [4:0]                       reps;
      logic                             typed;   // 1: use the typed-in result below
      deque_result_type                 result;
   } op_row_type;

   localparam int N_ROWS = 24;
   localparam op_row_type DIRECTED_OPS [N_ROWS] = '{
      // empty deque right after reset
      '{rbd_pkg::MODE_POP_FRONT, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
      '{rbd_pkg::MODE_POP_BACK, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}},
      '{rbd_pkg::MODE_READ, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_RANGE}},
      '{rbd_pkg::MODE_OVERWRITE, 4'd15, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_RANGE}},
      '{MODE_UNUSED_A, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      // first pushes; push front from head 0 wraps to the top slot
      '{rbd_pkg::MODE_PUSH_BACK, 4'd0, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{32'hFFFF_FFFF, 5'd1, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_PUSH_FRONT, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd2, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_PUSH_FRONT, 4'd0, 32'h8000_0001, 5'd1, 1'b1,
        '{32'h8000_0001, 5'd3, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_READ, 4'd0, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_READ, 4'd2, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_READ, 4'd3, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd3, rbd_pkg::ST_RANGE}},
      '{rbd_pkg::MODE_OVERWRITE, 4'd1, 32'h5A5A_5A5A, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_POP_BACK, 4'd0, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_POP_FRONT, 4'd0, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{MODE_UNUSED_B, 4'd15, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{32'h0, 5'd1, rbd_pkg::ST_OK}},
      // fill up, then both pushes must bounce
      '{rbd_pkg::MODE_PUSH_BACK, 4'd0, 32'h0001_0000, 5'd15, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_PUSH_FRONT, 4'd0, 32'h1234_5678, 5'd1, 1'b1,
        '{32'h0, 5'd16, rbd_pkg::ST_FULL}},
      '{rbd_pkg::MODE_PUSH_BACK, 4'd0, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{32'h0, 5'd16, rbd_pkg::ST_FULL}},
      '{rbd_pkg::MODE_READ, 4'd15, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_OVERWRITE, 4'd15, 32'hA5A5_A5A5, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_OVERWRITE, 4'd0, 32'h0, 5'd1, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      // drain from both ends
      '{rbd_pkg::MODE_POP_BACK, 4'd0, 32'h0, 5'd8, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_POP_FRONT, 4'd0, 32'h0, 5'd8, 1'b0,
        '{32'h0, 5'd0, rbd_pkg::ST_OK}},
      '{rbd_pkg::MODE_POP_FRONT, 4'd0, 32'h0, 5'd1, 1'b1,
        '{32'h0, 5'd0, rbd_pkg::ST_EMPTY}}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [rbd_pkg::MODE_BITS-1:0]    req_mode = '0;
   logic [rbd_pkg::POS_BITS-1:0]     req_position = '0;
   logic [rbd_pkg::ELEMENT_BITS-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [rbd_pkg::ELEMENT_BITS-1:0] rsp_element;
   logic [rbd_pkg::COUNT_BITS-1:0]   rsp_count;
   logic [rbd_pkg::STATUS_BITS-1:0]  rsp_status;

   ring_buffer_deque dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_element  (rsp_element),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

   always #5 clock = ~clock;

   // Deque model state: circular store, front slot and fill level.
   logic [rbd_pkg::ELEMENT_BITS-1:0] slot_mem [rbd_pkg::DEPTH];
   logic [rbd_pkg::SLOT_BITS-1:0]    front_slot = '0;
   logic [rbd_pkg::COUNT_BITS-1:0]   held_count = '0;

   deque_result_type deque_results [$];   // responses still owed by the block
   int               error_count = 0;
   int               quiet_cycles = 0;

   // Set by the driver with each request beat; typed_on selects the
   // hand-written result over the model's.
   logic             typed_on = 1'b0;
   deque_result_type typed_result;
   logic             no_idle = 1'b0;     // suppresses bubbles and stalls

   initial begin
      for (int i = 0; i < rbd_pkg::DEPTH; i++) slot_mem[i] = '0;
   end

   // Apply one operation to the model deque and return its response.
   // Slot math is done at SLOT_BITS width so it wraps like the store.
   function automatic deque_result_type apply_deque_op(
         logic [rbd_pkg::MODE_BITS-1:0] mode,
         logic [rbd_pkg::POS_BITS-1:0] pos,
         logic [rbd_pkg::ELEMENT_BITS-1:0] val);
      deque_result_type              r;
      logic [rbd_pkg::SLOT_BITS-1:0] slot;
      r.element = '0;
      r.status  = rbd_pkg::ST_OK;
      case (mode)
         rbd_pkg::MODE_PUSH_FRONT: begin
            if (held_count == rbd_pkg::DEPTH) r.status = rbd_pkg::ST_FULL;
            else begin
               front_slot = front_slot - 1'b1;
               slot_mem[front_slot] = val;
               held_count = held_count + 1'b1;
               r.element = val;
            end
         end
         rbd_pkg::MODE_PUSH_BACK: begin
            if (held_count == rbd_pkg::DEPTH) r.status = rbd_pkg::ST_FULL;
            else begin
               slot = front_slot + held_count[rbd_pkg::SLOT_BITS-1:0];
               slot_mem[slot] = val;
               held_count = held_count + 1'b1;
               r.element = val;
            end
         end
         rbd_pkg::MODE_POP_FRONT: begin
            if (held_count == 0) r.status = rbd_pkg::ST_EMPTY;
            else begin
               r.element = slot_mem[front_slot];
               front_slot = front_slot + 1'b1;
               held_count = held_count - 1'b1;
            end
         end
         rbd_pkg::MODE_POP_BACK: begin
            if (held_count == 0) r.status = rbd_pkg::ST_EMPTY;
            else begin
               held_count = held_count - 1'b1;
               slot = front_slot + held_count[rbd_pkg::SLOT_BITS-1:0];
               r.element = slot_mem[slot];
            end
         end
         rbd_pkg::MODE_READ: begin
            if ({1'b0, pos} >= held_count) r.status = rbd_pkg::ST_RANGE;
            else begin
               slot = front_slot + pos;
               r.element = slot_mem[slot];
            end
         end
         rbd_pkg::MODE_OVERWRITE: begin
            if ({1'b0, pos} >= held_count) r.status = rbd_pkg::ST_RANGE;
            else begin
               slot = front_slot + pos;
               r.element = slot_mem[slot];
               slot_mem[slot] = val;
            end
         end
         default: ;   // unused codes: no effect
      endcase
      r.count = held_count;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // All beats are observed here, at the rising edge. A request beat is
   // predicted before any response beat of the same edge is checked.
   always @(posedge clock) begin : beat_monitor
      logic             req_beat;
      logic             rsp_beat;
      deque_result_type predicted;
      deque_result_type owed;
      if (!reset) begin
         req_beat = req_valid && !req_stall;
         rsp_beat = rsp_valid && !rsp_stall;
         if (req_beat) begin
            predicted = apply_deque_op(req_mode, req_position, req_value);
            deque_results.push_back(typed_on ? typed_result : predicted);
         end
         if (rsp_beat) begin
            if (deque_results.size() == 0) begin
               flag_mismatch("unexpected response", rsp_element, '0);
            end else begin
               owed = deque_results.pop_front();
               if (rsp_element !== owed.element)
                  flag_mismatch("element", rsp_element, owed.element);
               if (rsp_count !== owed.count)
                  flag_mismatch("count", 32'(rsp_count), 32'(owed.count));
               if (rsp_status !== owed.status)
                  flag_mismatch("status", 32'(rsp_status), 32'(owed.status));
            end
         end
         // watchdog: a hung handshake ends the run
         if (req_beat || rsp_beat) quiet_cycles = 0;
         else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("FAILURE");
               $finish;
            end
         end
      end
   end

   // Response-side backpressure: random stall bursts.
   int stall_left = 0;
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Present one request beat (after an optional bubble) and hold it until
   // accepted. Called and returns at a falling edge.
   task automatic send_op(input logic [rbd_pkg::MODE_BITS-1:0] mode,
                          input logic [rbd_pkg::POS_BITS-1:0] pos,
                          input logic [rbd_pkg::ELEMENT_BITS-1:0] val,
                          input logic typed, input deque_result_type result);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      req_valid    <= 1'b1;
      typed_on      = typed;
      typed_result  = result;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin : stimulus
      deque_result_type              none;
      logic [rbd_pkg::MODE_BITS-1:0] mode;
      logic [rbd_pkg::POS_BITS-1:0]  pos;
      logic [31:0]                   val;
      logic                          filling;
      int                            pick;
      int                            push_weight;
      none = '0;
      filling = 1'b1;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (int r = 0; r < N_ROWS; r++) begin
         for (int i = 0; i < DIRECTED_OPS[r].reps; i++)
            send_op(DIRECTED_OPS[r].mode, DIRECTED_OPS[r].position,
                    DIRECTED_OPS[r].value + i, DIRECTED_OPS[r].typed,
                    DIRECTED_OPS[r].result);
      end

      // Random part: randomly chosen fill and drain stretches so the level
      // swings between empty and full and the head wraps often.
      for (int n = 0; n < RANDOM_OPS; n++) begin
         no_idle = (n >= RANDOM_OPS - QUIET_TAIL) || ((n / 80) % 3 == 2);
         if (n % 48 == 0) filling = 1'($urandom_range(0, 1));
         push_weight = filling ? 45 : 15;
         pick = $urandom_range(0, 99);
         if (pick < 3)
            mode = $urandom_range(0, 1) ? MODE_UNUSED_A : MODE_UNUSED_B;
         else if (pick < 3 + push_weight)
            mode = $urandom_range(0, 1) ? rbd_pkg::MODE_PUSH_FRONT
                                        : rbd_pkg::MODE_PUSH_BACK;
         else if (pick < 63)
            mode = $urandom_range(0, 1) ? rbd_pkg::MODE_POP_FRONT
                                        : rbd_pkg::MODE_POP_BACK;
         else
            mode = $urandom_range(0, 1) ? rbd_pkg::MODE_READ
                                        : rbd_pkg::MODE_OVERWRITE;
         // mostly in-range indexes, some anywhere
         if (held_count != 0 && $urandom_range(0, 4) != 0)
            pos = rbd_pkg::POS_BITS'($urandom_range(0, held_count - 1));
         else
            pos = rbd_pkg::POS_BITS'($urandom_range(0, 15));
         case ($urandom_range(0, 7))
            0:       val = 32'h0000_0000;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
         endcase
         send_op(mode, pos, val, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (deque_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
